// ----- hdl/fvn_pkg.sv -----
// Shared constants, types and hash constants for the fractal value noise block.
package fvn_pkg;

   // Octave pipeline sizing
   localparam int MAX_OCTAVES = 8;
   localparam int CNT_W       = $clog2(MAX_OCTAVES + 1);
   localparam int NORM_W      = 32 + $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W       = 64;
   localparam int DEN_W       = NORM_W + 8;
   localparam int QUO_W       = 17;
   localparam int OCT_STAGES  = 16;
   localparam int LATENCY     = 1 + OCT_STAGES * MAX_OCTAVES + 1 + QUO_W + 1;

   // Config port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEED       = 3'd0,
      CSR_OCTAVES    = 3'd1,
      CSR_LACUNARITY = 3'd2,
      CSR_GAIN       = 3'd3,
      CSR_MODE       = 3'd4
   } csr_index_type;

   localparam logic MODE_FBM    = 1'b0;
   localparam logic MODE_RIDGED = 1'b1;

   // Hash constants
   localparam logic [31:0] K_MIX1 = 32'h7feb352d;
   localparam logic [31:0] K_MIX2 = 32'h846ca68b;
   localparam logic [31:0] K_X    = 32'h8da6b343;
   localparam logic [31:0] K_Y    = 32'hd8163841;
   localparam logic [31:0] K_S    = 32'hcb1ab31f;
   localparam logic [31:0] SEED_STEP_FBM    = 32'd101;
   localparam logic [31:0] SEED_STEP_RIDGED = 32'd131;

   // Fixed-point constants
   localparam logic [16:0] ONE16     = 17'h10000;
   localparam logic [24:0] ONE24     = 25'h1000000;
   localparam logic [36:0] FADE_TEN  = 37'd10 << 32;
   localparam logic [47:0] FREQ_INIT = 48'h10000;
   localparam logic [31:0] AMP_INIT  = 32'd32768;

   typedef struct packed {
      logic        mode;
      logic [15:0] lacunarity;
      logic [16:0] gain;
   } cfg_type;

   // Per-item context passed from octave to octave
   typedef struct packed {
      logic                    valid;
      logic [31:0]             x;
      logic [31:0]             y;
      logic [47:0]             freq;
      logic [31:0]             amp;
      logic signed [SUM_W-1:0] sum;
      logic [NORM_W-1:0]       norm;
      logic [24:0]             prev;
      logic [31:0]             seed;
      logic [CNT_W-1:0]        cnt;
      logic [47:0]             freq_nx;
      logic [31:0]             amp_nx;
   } ctx_type;

   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [63:0]       rem;
      logic [DEN_W-1:0]  den;
      logic [QUO_W-1:0]  q;
   } div_type;

endpackage

// ----- hdl/fractal_value_noise.sv -----
// Top level: config registers, octave chain, restoring divider and output register.
// From start to rsp_strobe: input register, the fvn_pkg::OCT_STAGES stages of each of the
//   8 octave slots, divider load register, 17 divider steps and output register.
// Throughput: one point per cycle; busy stays low, every octave slot is a fixed pipeline.
// Reset: clears all valid bits and loads config defaults (seed 0, 4 octaves, lacunarity 2.0,
//   gain 0.5, fbm mode). Results cannot be held off and appear for one cycle each.
module fractal_value_noise (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [31:0]                  req_x_coord,
   input  logic signed [31:0]                  req_y_coord,
   output logic                                rsp_strobe,
   output logic signed [17:0]                  rsp_noise_value,
   input  logic                                csr_write_en,
   input  logic [fvn_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fvn_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Config registers
   logic [31:0] noise_seed_ff;
   logic [3:0]  octave_count_ff;
   logic [15:0] lacunarity_ff;
   logic [16:0] gain_ff;
   logic        noise_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_seed_ff   <= 32'd0;
         octave_count_ff <= 4'd4;
         lacunarity_ff   <= 16'd8192;
         gain_ff         <= 17'd32768;
         noise_mode_ff   <= fvn_pkg::MODE_FBM;
      end else if (csr_write_en) begin
         unique case (csr_index)
            fvn_pkg::CSR_SEED:       noise_seed_ff   <= csr_wdata;
            fvn_pkg::CSR_OCTAVES:    octave_count_ff <= csr_wdata[3:0];
            fvn_pkg::CSR_LACUNARITY: lacunarity_ff   <= csr_wdata[15:0];
            fvn_pkg::CSR_GAIN:       gain_ff         <= csr_wdata[16:0];
            fvn_pkg::CSR_MODE:       noise_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   fvn_pkg::cfg_type cfg;
   assign cfg = '{mode: noise_mode_ff, lacunarity: lacunarity_ff, gain: gain_ff};

   // Input register: clamp octave count and seed the context
   logic [fvn_pkg::CNT_W-1:0] cnt_in;
   fvn_pkg::ctx_type          ctx_in;
   fvn_pkg::ctx_type          ctx0_ff;

   always_comb begin
      if (octave_count_ff == 4'd0) begin
         cnt_in = fvn_pkg::CNT_W'(1);
      end else if (int'(octave_count_ff) > fvn_pkg::MAX_OCTAVES) begin
         cnt_in = fvn_pkg::CNT_W'(fvn_pkg::MAX_OCTAVES);
      end else begin
         cnt_in = fvn_pkg::CNT_W'(octave_count_ff);
      end
      ctx_in.valid   = start & ~busy;
      ctx_in.x       = req_x_coord;
      ctx_in.y       = req_y_coord;
      ctx_in.freq    = fvn_pkg::FREQ_INIT;
      ctx_in.amp     = fvn_pkg::AMP_INIT;
      ctx_in.sum     = '0;
      ctx_in.norm    = '0;
      ctx_in.prev    = fvn_pkg::ONE24;
      ctx_in.seed    = noise_seed_ff;
      ctx_in.cnt     = cnt_in;
      ctx_in.freq_nx = '0;
      ctx_in.amp_nx  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx0_ff.valid <= 1'b0;
      end else begin
         ctx0_ff <= ctx_in;
      end
   end

   assign busy = 1'b0;

   // Octave chain
   fvn_pkg::ctx_type oct_ctx [fvn_pkg::MAX_OCTAVES+1];
   assign oct_ctx[0] = ctx0_ff;

   for (genvar g = 0; g < fvn_pkg::MAX_OCTAVES; g++) begin : g_oct
      fvn_octave u_octave (
         .clock   (clock),
         .reset   (reset),
         .cfg_in  (cfg),
         .ctx_in  (oct_ctx[g]),
         .ctx_out (oct_ctx[g+1])
      );
   end

   // Normalize: restoring divide of |sum| by norm*256, one quotient bit per stage
   fvn_pkg::ctx_type last_ctx;
   fvn_pkg::div_type div_load;
   fvn_pkg::div_type div_in [fvn_pkg::QUO_W+1];
   fvn_pkg::div_type div_ff [fvn_pkg::QUO_W+1];
   logic [63:0]      trial [fvn_pkg::QUO_W];

   assign last_ctx = oct_ctx[fvn_pkg::MAX_OCTAVES];

   always_comb begin
      div_load.valid = last_ctx.valid;
      div_load.neg   = last_ctx.sum[fvn_pkg::SUM_W-1];
      div_load.rem   = last_ctx.sum[fvn_pkg::SUM_W-1] ? 64'(-last_ctx.sum)
                                                      : 64'(last_ctx.sum);
      div_load.den   = {last_ctx.norm, 8'd0};
      div_load.q     = '0;
      div_in[0]      = div_load;
      for (int j = 0; j < fvn_pkg::QUO_W; j++) begin
         trial[j]    = 64'(div_ff[j].den) << (fvn_pkg::QUO_W - 1 - j);
         div_in[j+1] = div_ff[j];
         if (div_ff[j].rem >= trial[j]) begin
            div_in[j+1].rem                         = div_ff[j].rem - trial[j];
            div_in[j+1].q[fvn_pkg::QUO_W - 1 - j]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= fvn_pkg::QUO_W; j++) begin
            div_ff[j].valid <= 1'b0;
         end
      end else begin
         div_ff[0] <= div_in[0];
         for (int j = 1; j <= fvn_pkg::QUO_W; j++) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // Sign, saturate and drive the result
   logic [17:0]        mag;
   logic signed [17:0] res;
   logic               rsp_strobe_ff;
   logic signed [17:0] rsp_noise_value_ff;

   always_comb begin
      mag = (18'(div_ff[fvn_pkg::QUO_W].q) > 18'd65536) ? 18'd65536
                                                         : 18'(div_ff[fvn_pkg::QUO_W].q);
      res = div_ff[fvn_pkg::QUO_W].neg ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_ff[fvn_pkg::QUO_W].valid;
      end
      rsp_noise_value_ff <= res;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

endmodule

// ----- hdl/fvn_octave.sv -----
// One octave of value noise: lattice hash, quintic fade, bilinear blend, ridge shaping in ridged mode, accumulate.
module fvn_octave (
   input  logic             clock,
   input  logic             reset,
   input  fvn_pkg::cfg_type cfg_in,
   input  fvn_pkg::ctx_type ctx_in,
   output fvn_pkg::ctx_type ctx_out
);

   function automatic logic [31:0] mix_a(input logic [31:0] v);
      logic [31:0] u;
      u = v ^ (v >> 16);
      mix_a = u * fvn_pkg::K_MIX1;
   endfunction

   function automatic logic [31:0] mix_b(input logic [31:0] v);
      logic [31:0] u;
      u = v ^ (v >> 15);
      mix_b = u * fvn_pkg::K_MIX2;
   endfunction

   function automatic logic [31:0] mix_c(input logic [31:0] v);
      mix_c = v ^ (v >> 16);
   endfunction

   fvn_pkg::ctx_type ctx_ff [fvn_pkg::OCT_STAGES];
   fvn_pkg::ctx_type ctx1_in;
   fvn_pkg::ctx_type ctx16_in;

   // stage 1: coordinate scaling, next freq/amp, seed hash
   logic signed [64:0] prodx, prody;
   logic [31:0]        phx_in, phy_in, ms_in;
   logic [63:0]        fmul;
   logic [48:0]        amul;
   logic [63:0]        plx1_ff, ply1_ff;
   logic [31:0]        phx1_ff, phy1_ff, ms1_ff;

   always_comb begin
      prodx   = $signed(ctx_in.x) * $signed({1'b0, ctx_in.freq[31:0]});
      prody   = $signed(ctx_in.y) * $signed({1'b0, ctx_in.freq[31:0]});
      phx_in  = ctx_in.x * ctx_in.freq[47:32];
      phy_in  = ctx_in.y * ctx_in.freq[47:32];
      ms_in   = ctx_in.seed * fvn_pkg::K_S;
      fmul    = ctx_in.freq * cfg_in.lacunarity;
      amul    = ctx_in.amp * cfg_in.gain;
      ctx1_in = ctx_in;
      if (cfg_in.mode == fvn_pkg::MODE_RIDGED) begin
         ctx1_in.freq_nx = {ctx_in.freq[46:0], 1'b0};
         ctx1_in.amp_nx  = {1'b0, ctx_in.amp[31:1]};
      end else begin
         ctx1_in.freq_nx = fmul[59:12];
         ctx1_in.amp_nx  = amul[48] ? 32'hFFFF_FFFF : amul[47:16];
      end
   end

   // stage 2: lattice index and fraction
   logic [31:0] ix2_ff, ix12_ff, iy2_ff, iy12_ff, ms2_ff;
   logic [15:0] tx2_ff, ty2_ff;
   logic [31:0] ix_s2, iy_s2;

   always_comb begin
      ix_s2 = plx1_ff[63:32] + phx1_ff;
      iy_s2 = ply1_ff[63:32] + phy1_ff;
   end

   // stage 3: corner hash multiplies, fade squares
   logic [31:0] hx0_3_ff, hx1_3_ff, hy0_3_ff, hy1_3_ff, ttx3_ff, tty3_ff;
   logic [15:0] tx3_ff, ty3_ff;

   // stage 4: inner mix first half, fade cube and polynomial
   logic [31:0] iv0_4_ff, iv1_4_ff, hx0_4_ff, hx1_4_ff, t3px4_ff, t3py4_ff;
   logic [35:0] px4_ff, py4_ff;
   logic [36:0] px_s4, py_s4;

   always_comb begin
      px_s4 = 37'(ttx3_ff) * 37'd6 + fvn_pkg::FADE_TEN - ((37'(tx3_ff) * 37'd15) << 16);
      py_s4 = 37'(tty3_ff) * 37'd6 + fvn_pkg::FADE_TEN - ((37'(ty3_ff) * 37'd15) << 16);
   end

   // stage 5: inner mix second half, fade product
   logic [31:0] iv0_5_ff, iv1_5_ff, hx0_5_ff, hx1_5_ff;
   logic [51:0] fpx5_ff, fpy5_ff;

   // stage 6: outer mix first half, fade cap
   logic [31:0] ov6_ff [4];
   logic [31:0] in0_s6, in1_s6;
   logic [16:0] fx6_ff, fy6_ff;

   always_comb begin
      in0_s6 = mix_c(iv0_5_ff);
      in1_s6 = mix_c(iv1_5_ff);
   end

   // stage 7: outer mix second half
   logic [31:0] ov7_ff [4];
   logic [16:0] fx7_ff, fy7_ff;

   // stage 8: corner values and first blend multiplies
   logic [23:0] cv_s8 [4];
   logic [40:0] ma8_ff, mb8_ff, mc8_ff, md8_ff;
   logic [16:0] fy8_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         cv_s8[c] = 24'(mix_c(ov7_ff[c]) >> 8);
      end
   end

   // stage 9..11: blend in x, blend in y, signed noise
   logic [41:0] e0_s9, e1_s9;
   logic [23:0] e0_9_ff, e1_9_ff;
   logic [16:0] fy9_ff;
   logic [40:0] m0_10_ff, m1_10_ff;
   logic [41:0] v_s11;
   logic signed [24:0] n11_ff, n12_ff, n13_ff, n14_ff;

   always_comb begin
      e0_s9 = 42'(ma8_ff) + 42'(mb8_ff);
      e1_s9 = 42'(mc8_ff) + 42'(md8_ff);
      v_s11 = 42'(m0_10_ff) + 42'(m1_10_ff);
   end

   // stage 12..15: ridge shaping and weighted term
   logic [24:0] abs_s12, r12_ff, s13_ff, s14_ff, s15_ff, w14_ff;
   logic [49:0] rr_s13, sp_s14;
   logic signed [25:0] op_s15;
   logic signed [58:0] term_s15, term15_ff;

   always_comb begin
      abs_s12  = n11_ff[24] ? 25'(-n11_ff) : n11_ff;
      rr_s13   = r12_ff * r12_ff;
      sp_s14   = s13_ff * ctx_ff[12].prev;
      op_s15   = (cfg_in.mode == fvn_pkg::MODE_RIDGED) ? $signed({1'b0, w14_ff})
                                                       : 26'(n14_ff);
      term_s15 = $signed({1'b0, ctx_ff[13].amp}) * op_s15;
   end

   // stage 16: accumulate while octaves remain
   always_comb begin
      ctx16_in = ctx_ff[14];
      if (ctx_ff[14].cnt != '0) begin
         ctx16_in.sum  = ctx_ff[14].sum + {{(fvn_pkg::SUM_W-59){term15_ff[58]}}, term15_ff};
         ctx16_in.norm = ctx_ff[14].norm + fvn_pkg::NORM_W'(ctx_ff[14].amp);
         ctx16_in.amp  = ctx_ff[14].amp_nx;
         ctx16_in.freq = ctx_ff[14].freq_nx;
         ctx16_in.cnt  = ctx_ff[14].cnt - 1'b1;
         if (cfg_in.mode == fvn_pkg::MODE_RIDGED) begin
            ctx16_in.prev = s15_ff;
            ctx16_in.seed = ctx_ff[14].seed + fvn_pkg::SEED_STEP_RIDGED;
         end else begin
            ctx16_in.seed = ctx_ff[14].seed + fvn_pkg::SEED_STEP_FBM;
         end
      end
   end

   // context pipeline, valid bits reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < fvn_pkg::OCT_STAGES; k++) begin
            ctx_ff[k].valid <= 1'b0;
         end
      end else begin
         ctx_ff[0] <= ctx1_in;
         for (int k = 1; k < fvn_pkg::OCT_STAGES - 1; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
         end
         ctx_ff[fvn_pkg::OCT_STAGES-1] <= ctx16_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      plx1_ff <= prodx[63:0];
      ply1_ff <= prody[63:0];
      phx1_ff <= phx_in;
      phy1_ff <= phy_in;
      ms1_ff  <= ms_in;

      ix2_ff  <= ix_s2;
      ix12_ff <= ix_s2 + 32'd1;
      iy2_ff  <= iy_s2;
      iy12_ff <= iy_s2 + 32'd1;
      tx2_ff  <= plx1_ff[31:16];
      ty2_ff  <= ply1_ff[31:16];
      ms2_ff  <= ms1_ff;

      hx0_3_ff <= ix2_ff * fvn_pkg::K_X;
      hx1_3_ff <= ix12_ff * fvn_pkg::K_X;
      hy0_3_ff <= (iy2_ff * fvn_pkg::K_Y) ^ ms2_ff;
      hy1_3_ff <= (iy12_ff * fvn_pkg::K_Y) ^ ms2_ff;
      ttx3_ff  <= tx2_ff * tx2_ff;
      tty3_ff  <= ty2_ff * ty2_ff;
      tx3_ff   <= tx2_ff;
      ty3_ff   <= ty2_ff;

      iv0_4_ff <= mix_a(hy0_3_ff);
      iv1_4_ff <= mix_a(hy1_3_ff);
      hx0_4_ff <= hx0_3_ff;
      hx1_4_ff <= hx1_3_ff;
      t3px4_ff <= ttx3_ff[31:16] * tx3_ff;
      t3py4_ff <= tty3_ff[31:16] * ty3_ff;
      px4_ff   <= px_s4[35:0];
      py4_ff   <= py_s4[35:0];

      iv0_5_ff <= mix_b(iv0_4_ff);
      iv1_5_ff <= mix_b(iv1_4_ff);
      hx0_5_ff <= hx0_4_ff;
      hx1_5_ff <= hx1_4_ff;
      fpx5_ff  <= t3px4_ff[31:16] * px4_ff;
      fpy5_ff  <= t3py4_ff[31:16] * py4_ff;

      ov6_ff[0] <= mix_a(hx0_5_ff ^ in0_s6);
      ov6_ff[1] <= mix_a(hx1_5_ff ^ in0_s6);
      ov6_ff[2] <= mix_a(hx0_5_ff ^ in1_s6);
      ov6_ff[3] <= mix_a(hx1_5_ff ^ in1_s6);
      fx6_ff    <= (fpx5_ff[51:32] > 20'(fvn_pkg::ONE16)) ? fvn_pkg::ONE16 : fpx5_ff[48:32];
      fy6_ff    <= (fpy5_ff[51:32] > 20'(fvn_pkg::ONE16)) ? fvn_pkg::ONE16 : fpy5_ff[48:32];

      for (int c = 0; c < 4; c++) begin
         ov7_ff[c] <= mix_b(ov6_ff[c]);
      end
      fx7_ff <= fx6_ff;
      fy7_ff <= fy6_ff;

      ma8_ff <= cv_s8[0] * (fvn_pkg::ONE16 - fx7_ff);
      mb8_ff <= cv_s8[1] * fx7_ff;
      mc8_ff <= cv_s8[2] * (fvn_pkg::ONE16 - fx7_ff);
      md8_ff <= cv_s8[3] * fx7_ff;
      fy8_ff <= fy7_ff;

      e0_9_ff <= e0_s9[39:16];
      e1_9_ff <= e1_s9[39:16];
      fy9_ff  <= fy8_ff;

      m0_10_ff <= e0_9_ff * (fvn_pkg::ONE16 - fy9_ff);
      m1_10_ff <= e1_9_ff * fy9_ff;

      n11_ff <= $signed({v_s11[39:16], 1'b0} - fvn_pkg::ONE24);

      r12_ff <= fvn_pkg::ONE24 - abs_s12;
      n12_ff <= n11_ff;

      s13_ff <= rr_s13[48:24];
      n13_ff <= n12_ff;

      w14_ff <= sp_s14[48:24];
      s14_ff <= s13_ff;
      n14_ff <= n13_ff;

      term15_ff <= term_s15;
      s15_ff    <= s14_ff;
   end

   assign ctx_out = ctx_ff[fvn_pkg::OCT_STAGES-1];

endmodule

// ----- hdl/fvn_checker.sv -----
// Port-level checks for the fractal value noise block, bound to the top level.
module fvn_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [17:0] rsp_noise_value
);

   // The block never refuses a transfer
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy asserted");

   // Every result traces back to a transfer exactly one latency earlier
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, fvn_pkg::LATENCY))
      else $error("result without matching request");

   // Results stay within plus or minus one
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_noise_value <= 18'sd65536 && rsp_noise_value >= -18'sd65536))
      else $error("result out of range");

   // Nothing leaves the pipeline right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_strobe)
      else $error("result right after reset");

endmodule

bind fractal_value_noise fvn_checker u_fvn_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_noise_value (rsp_noise_value)
);

// ----- test/tb_fractal_value_noise.sv -----
// Self-checking testbench for fractal_value_noise: directed, register and random point streams.
`timescale 1ns / 1ps

module tb_fractal_value_noise;

   localparam logic [fvn_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam longint FIX_ONE24 = 64'sh1000000;
   localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic signed [31:0]                  req_x_coord = '0;
   logic signed [31:0]                  req_y_coord = '0;
   logic                                rsp_strobe;
   logic signed [17:0]                  rsp_noise_value;
   logic                                csr_write_en = 1'b0;
   logic [fvn_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [fvn_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   // Shadow copy of the block's registers
   logic [31:0] seed_q;
   logic [3:0]  octaves_q;
   logic [15:0] lacunarity_q;
   logic [16:0] gain_q;
   logic        mode_q;

   logic signed [17:0] noise_expected[$];
   int errors = 0;
   int sent = 0;
   int checked = 0;
   bit steady = 1'b0;

   fractal_value_noise dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .rsp_strobe(rsp_strobe), .rsp_noise_value(rsp_noise_value),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Integer hash used for lattice corners
   function automatic logic [31:0] hash_mix(logic [31:0] v);
      v = v ^ (v >> 16);
      v = v * fvn_pkg::K_MIX1;
      v = v ^ (v >> 15);
      v = v * fvn_pkg::K_MIX2;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic logic [63:0] lattice_value(logic [31:0] cx, logic [31:0] cy,
                                                 logic [31:0] s);
      logic [31:0] hy, hs, inner, hx;
      hy = cy * fvn_pkg::K_Y;
      hs = s * fvn_pkg::K_S;
      inner = hash_mix(hy ^ hs);
      hx = cx * fvn_pkg::K_X;
      return {32'b0, hash_mix(hx ^ inner) >> 8};
   endfunction

   function automatic logic [63:0] quintic_fade(logic [63:0] t);
      logic [63:0] t2, t3, p, f;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      p = 64'd6 * t * t + (64'd10 << 32) - ((64'd15 * t) << 16);
      f = (t3 * p) >> 32;
      return (f > 64'd65536) ? 64'd65536 : f;
   endfunction

   function automatic logic [63:0] lerp16(logic [63:0] a, logic [63:0] b, logic [63:0] f);
      return (a * (64'd65536 - f) + b * f) >> 16;
   endfunction

   // One octave, signed Q1.24
   function automatic longint octave_sample(logic [31:0] x, logic [31:0] y,
                                            logic [63:0] freq, logic [31:0] s);
      logic [63:0] px, py, fx, fy, a, b, c, d, v;
      logic [31:0] ix, iy;
      px = {{32{x[31]}}, x} * freq;
      py = {{32{y[31]}}, y} * freq;
      ix = px[63:32];
      iy = py[63:32];
      fx = quintic_fade({48'b0, px[31:16]});
      fy = quintic_fade({48'b0, py[31:16]});
      a = lattice_value(ix, iy, s);
      b = lattice_value(ix + 32'd1, iy, s);
      c = lattice_value(ix, iy + 32'd1, s);
      d = lattice_value(ix + 32'd1, iy + 32'd1, s);
      v = lerp16(lerp16(a, b, fx), lerp16(c, d, fx), fy);
      return 2 * longint'(v) - FIX_ONE24;
   endfunction

   function automatic logic signed [17:0] fractal_noise(logic [31:0] x, logic [31:0] y);
      int count;
      logic [63:0] freq, amp, norm;
      longint sum, prev, n, r, s, w, res;
      freq = 64'h10000;
      amp = 64'd32768;
      norm = '0;
      sum = 0;
      prev = FIX_ONE24;
      count = (octaves_q < 1) ? 1
            : ((octaves_q > fvn_pkg::MAX_OCTAVES) ? fvn_pkg::MAX_OCTAVES : octaves_q);
      for (int i = 0; i < count; i++) begin
         if (mode_q == fvn_pkg::MODE_FBM) begin
            n = octave_sample(x, y, freq, seed_q + 32'(i) * fvn_pkg::SEED_STEP_FBM);
            sum += longint'(amp) * n;
            norm += amp;
            amp = (amp * gain_q) >> 16;
            if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
            freq = ((freq * lacunarity_q) >> 12) & MASK48;
         end else begin
            n = octave_sample(x, y, freq, seed_q + 32'(i) * fvn_pkg::SEED_STEP_RIDGED);
            r = FIX_ONE24 - ((n < 0) ? -n : n);
            s = (r * r) >>> 24;
            w = (s * prev) >>> 24;
            sum += longint'(amp) * w;
            prev = s;
            norm += amp;
            amp = amp >> 1;
            freq = (freq << 1) & MASK48;
         end
      end
      res = sum / longint'(norm * 256);
      if (res > 65536) res = 65536;
      if (res < -65536) res = -65536;
      return res[17:0];
   endfunction

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (noise_expected.size() == 0) begin
            $error("noise_value: unexpected result %0d", rsp_noise_value);
            errors++;
         end else begin
            if (rsp_noise_value !== noise_expected[0]) begin
               $error("noise_value: expected %0d, got %0d", noise_expected[0],
                      rsp_noise_value);
               errors++;
            end
            void'(noise_expected.pop_front());
            checked++;
         end
      end
   end

   // One point transfer, with random idle cycles before it unless the stream is steady
   task automatic send_point(logic [31:0] x, logic [31:0] y);
      while (!steady && $urandom_range(99) < 38) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (busy);
      noise_expected.push_back(fractal_noise(x, y));
      sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [fvn_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         fvn_pkg::CSR_SEED:       seed_q = val;
         fvn_pkg::CSR_OCTAVES:    octaves_q = val[3:0];
         fvn_pkg::CSR_LACUNARITY: lacunarity_q = val[15:0];
         fvn_pkg::CSR_GAIN:       gain_q = val[16:0];
         fvn_pkg::CSR_MODE:       mode_q = val[0];
         default: ;
      endcase
   endtask

   task automatic setup(logic [31:0] s, logic [3:0] oct, logic [15:0] lac,
                        logic [16:0] g, logic m);
      drain();
      write_reg(fvn_pkg::CSR_SEED, s);
      write_reg(fvn_pkg::CSR_OCTAVES, {28'b0, oct});
      write_reg(fvn_pkg::CSR_LACUNARITY, {16'b0, lac});
      write_reg(fvn_pkg::CSR_GAIN, {15'b0, g});
      write_reg(fvn_pkg::CSR_MODE, {31'b0, m});
   endtask

   // Field extremes, fractions and lattice wrap at default settings
   task automatic test_directed_points();
      send_point(32'h0, 32'h0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'h0000_0001);
      send_point(32'h0000_8000, 32'hFFFF_8000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h0001_FFFF, 32'hFFFE_0001);
      send_point(32'h1234_5678, 32'hEDCB_A988);
   endtask

   // Register corners: octave clamps, zero lacunarity, large gain, ridged mode
   task automatic test_register_corners();
      setup(32'hFFFF_FFFF, 4'd0, 16'd8192, 17'd32768, fvn_pkg::MODE_FBM);
      send_point(32'h0003_4000, 32'hFFFC_C000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      setup(32'h0, 4'd15, 16'd65535, 17'd65536, fvn_pkg::MODE_FBM);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h0000_0001);
      setup(32'hA5A5_5A5A, 4'd8, 16'd0, 17'd131071, fvn_pkg::MODE_FBM);
      send_point(32'h0010_0000, 32'hFFEF_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      setup(32'h1, 4'd8, 16'd0, 17'd0, fvn_pkg::MODE_RIDGED);
      send_point(32'h0, 32'h0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'hFFFF_8000, 32'h0000_8000);
      setup(32'h0, 4'd1, 16'd1, 17'd1, fvn_pkg::MODE_RIDGED);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      send_point(32'h0002_0000, 32'h0003_0000);
   endtask

   // Random points over random settings; first phase without idling
   task automatic test_random_stream();
      logic [31:0] x, y;
      for (int ph = 0; ph < 10; ph++) begin
         setup($urandom, 4'($urandom_range(15)),
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 12288)),
               ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                        : 17'($urandom_range(65536)),
               1'($urandom_range(1)));
         steady = (ph == 0);
         for (int k = 0; k < 128; k++) begin
            if ($urandom_range(1)) begin
               x = $urandom;
               y = $urandom;
            end else begin
               x = 32'($signed($urandom_range(2097152)) - 1048576);
               y = 32'($signed($urandom_range(2097152)) - 1048576);
            end
            send_point(x, y);
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      seed_q = '0;
      octaves_q = 4'd4;
      lacunarity_q = 16'd8192;
      gain_q = 17'd32768;
      mode_q = fvn_pkg::MODE_FBM;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_points();
      test_register_corners();
      test_random_stream();
      drain();
      repeat (fvn_pkg::LATENCY + 20) @(posedge clock);
      if (noise_expected.size() != 0) begin
         $error("noise_value: %0d results never arrived", noise_expected.size());
         errors++;
      end
      $display("Covered %0d points, %0d results checked, fbm and ridged modes,", sent, checked);
      $display("octave clamps, zero lacunarity, large gain and lattice wrap.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
